FILE: src/ltps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltps_pkg
// Types, codes and thresholds shared by the load tracking profile selector.
// ----------------------------------------------------------------------------
package ltps_pkg;

  typedef enum logic [1:0] {
    OP_CPU_SAMPLE = 2'd0,
    OP_GPU_SAMPLE = 2'd1,
    OP_MODE_QUERY = 2'd2,
    OP_SET_MODE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CLUSTER_PERF  = 2'd0,
    CLUSTER_PRIME = 2'd1
  } cluster_e;

  typedef enum logic [1:0] {
    REG_AUTO_ENABLE       = 2'd0,
    REG_AUTO_BOOST_ENABLE = 2'd1,
    REG_HOLD_TIME_MS      = 2'd2
  } reg_idx_e;

  typedef logic [1:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  // profile mode codes
  localparam logic [2:0] MODE_OFF         = 3'd0;
  localparam logic [2:0] MODE_SAVE        = 3'd1;
  localparam logic [2:0] MODE_BALANCE     = 3'd2;
  localparam logic [2:0] MODE_PERFORMANCE = 3'd3;
  localparam logic [2:0] MODE_GAMING      = 3'd4;

  // cpu high-load thresholds
  localparam logic [6:0]  LOAD_PERF  = 7'd85;
  localparam logic [6:0]  LOAD_PRIME = 7'd80;
  localparam logic [31:0] FREQ_PERF  = 32'd2246400;
  localparam logic [31:0] FREQ_PRIME = 32'd2265600;

  // hold time, kept in nanoseconds
  localparam int unsigned HOLD_NS_W     = 36;
  localparam logic [19:0] NS_PER_MS     = 20'd1000000;
  localparam logic [15:0] HOLD_MS_RESET = 16'd1000;

  // gpu frequency thresholds in Hz
  localparam logic [31:0] GPU_FREQ_600 = 32'd600000000;
  localparam logic [31:0] GPU_FREQ_550 = 32'd550000000;
  localparam logic [31:0] GPU_FREQ_500 = 32'd500000000;
  localparam logic [31:0] GPU_FREQ_450 = 32'd450000000;
  localparam logic [31:0] GPU_FREQ_400 = 32'd400000000;

  // gpu busy thresholds before cpu balance offset
  localparam logic [7:0] BUSY_UP = 8'd70;
  localparam logic [7:0] BUSY_HI = 8'd80;
  localparam logic [7:0] BUSY_DN = 8'd40;

  // step counter limits
  localparam logic signed [7:0]  INST_MAX = 8'sd20;
  localparam logic signed [7:0]  INST_MIN = -8'sd60;
  localparam logic signed [7:0]  INST_SET = 8'sd10;
  localparam logic signed [7:0]  INST_CLR = -8'sd30;
  localparam logic signed [12:0] LONG_MAX = 13'sd4000;
  localparam logic signed [12:0] LONG_MIN = -13'sd200;
  localparam logic signed [12:0] LONG_SET = 13'sd2000;
  localparam logic signed [12:0] LONG_CLR = -13'sd100;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  cluster;
    logic [31:0] frequency;
    logic [6:0]  cpu_load;
    logic [63:0] timestamp_ns;
    logic [6:0]  gpu_busy;
    logic [2:0]  level;
    logic        display_on;
  } item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       boost;
    logic       gpu_instant_high;
    logic       gpu_longtime_high;
    logic       cpu_long_perf;
    logic       cpu_long_prime;
  } result_t;

  typedef struct packed {
    logic instant_high;
    logic longtime_high;
  } gpu_flags_t;

endpackage

FILE: src/ltps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltps_if
// Valid/ready channels for sample items and status results.
// ----------------------------------------------------------------------------
interface ltps_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  cluster;
  logic [31:0] frequency;
  logic [6:0]  cpu_load;
  logic [63:0] timestamp_ns;
  logic [6:0]  gpu_busy;
  logic [2:0]  level;
  logic        display_on;

  modport source (
    output valid, op, cluster, frequency, cpu_load, timestamp_ns, gpu_busy,
           level, display_on,
    input  ready
  );
  modport sink (
    input  valid, op, cluster, frequency, cpu_load, timestamp_ns, gpu_busy,
           level, display_on,
    output ready
  );
endinterface

interface ltps_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       boost;
  logic       gpu_instant_high;
  logic       gpu_longtime_high;
  logic       cpu_long_perf;
  logic       cpu_long_prime;

  modport source (
    output valid, mode, boost, gpu_instant_high, gpu_longtime_high,
           cpu_long_perf, cpu_long_prime,
    input  ready
  );
  modport sink (
    input  valid, mode, boost, gpu_instant_high, gpu_longtime_high,
           cpu_long_perf, cpu_long_prime,
    output ready
  );
endinterface

FILE: src/load_tracking_profile_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_tracking_profile_selector
// Picks a power profile mode and boost flag from cpu and gpu load samples.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries cpu samples, gpu samples, mode queries and set-mode
//   requests; each transfer yields exactly one status transfer on result_o,
//   reporting mode, boost and the tracking flags as they stand after it.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write auto_enable, auto_boost_enable and
//   hold_time_ms; write only while no item is in flight.
//   An item first sits in the input register; when it advances, its result
//   is written to the output register and result valid rises with it.
//   Throughput: one item per cycle while result_o is not stalled; all
//   tracking state updates in the single step between input and output
//   register.
//   A stalled result_o holds its data; the input register still takes one
//   more item, then item_i.ready drops until the result is taken.
//   Reset clears all tracking flags and counters, mode and boost, and loads register
//   defaults (auto enables on, hold time 1000 ms). No warm-up is needed.
// ----------------------------------------------------------------------------
module load_tracking_profile_selector (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  ltps_pkg::cfg_idx_t   cfg_idx_i,
  input  ltps_pkg::cfg_data_t  cfg_wdata_i,
  ltps_item_if.sink            item_i,
  ltps_result_if.source        result_o
);
  import ltps_pkg::*;

  // configuration
  logic                 auto_en_q, auto_boost_q;
  logic [HOLD_NS_W-1:0] hold_ns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en_q    <= 1'b1;
      auto_boost_q <= 1'b1;
      hold_ns_q    <= HOLD_NS_W'(HOLD_MS_RESET) * HOLD_NS_W'(NS_PER_MS);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_AUTO_ENABLE:       auto_en_q    <= cfg_wdata_i[0];
        REG_AUTO_BOOST_ENABLE: auto_boost_q <= cfg_wdata_i[0];
        REG_HOLD_TIME_MS: begin
          hold_ns_q <= HOLD_NS_W'(cfg_wdata_i) * HOLD_NS_W'(NS_PER_MS);
        end
        default: ;
      endcase
    end
  end

  // input register and output register
  logic    in_valid_q, out_valid_q, advance;
  item_t   item_q;
  result_t res_q, res_d;

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.op           <= item_i.op;
      item_q.cluster      <= item_i.cluster;
      item_q.frequency    <= item_i.frequency;
      item_q.cpu_load     <= item_i.cpu_load;
      item_q.timestamp_ns <= item_i.timestamp_ns;
      item_q.gpu_busy     <= item_i.gpu_busy;
      item_q.level        <= item_i.level;
      item_q.display_on   <= item_i.display_on;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // per-op update strobes
  op_e  op;
  logic upd_perf, upd_prime, upd_gpu, is_query, is_set;
  logic hit_perf, hit_prime;

  always_comb begin
    op        = op_e'(item_q.op);
    upd_perf  = 1'b0;
    upd_prime = 1'b0;
    upd_gpu   = 1'b0;
    is_query  = 1'b0;
    is_set    = 1'b0;
    case (op)
      OP_CPU_SAMPLE: begin
        case (cluster_e'(item_q.cluster))
          CLUSTER_PERF:  upd_perf  = advance;
          CLUSTER_PRIME: upd_prime = advance;
          default: ;
        endcase
      end
      OP_GPU_SAMPLE: upd_gpu  = advance;
      OP_MODE_QUERY: is_query = 1'b1;
      OP_SET_MODE:   is_set   = 1'b1;
      default: ;
    endcase
  end

  assign hit_perf  = (item_q.cpu_load >= LOAD_PERF) && (item_q.frequency >= FREQ_PERF);
  assign hit_prime = (item_q.cpu_load >= LOAD_PRIME) && (item_q.frequency >= FREQ_PRIME);

  logic       long_perf, long_prime;
  gpu_flags_t gpu_flags;

  ltps_cpu_track u_perf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd_perf),
    .hit_i       (hit_perf),
    .now_i       (item_q.timestamp_ns),
    .hold_ns_i   (hold_ns_q),
    .long_high_o (long_perf)
  );

  ltps_cpu_track u_prime (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd_prime),
    .hit_i       (hit_prime),
    .now_i       (item_q.timestamp_ns),
    .hold_ns_i   (hold_ns_q),
    .long_high_o (long_prime)
  );

  ltps_gpu_track u_gpu (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_i            (upd_gpu),
    .frequency_i      (item_q.frequency),
    .gpu_busy_i       (item_q.gpu_busy),
    .cpu_long_perf_i  (long_perf),
    .cpu_long_prime_i (long_prime),
    .flags_o          (gpu_flags)
  );

  // mode and boost
  logic [2:0] mode_q, mode_d;
  logic       boost_q, boost_d;

  always_comb begin
    mode_d  = mode_q;
    boost_d = boost_q;
    if (is_query) begin
      if (auto_en_q) begin
        if (!item_q.display_on) begin
          if (auto_boost_q) begin
            boost_d = 1'b0;
          end
          mode_d = MODE_SAVE;
        end else begin
          if (auto_boost_q) begin
            boost_d = gpu_flags.longtime_high;
          end
          if (gpu_flags.longtime_high && (long_perf || long_prime)) begin
            mode_d = MODE_GAMING;
          end else if (gpu_flags.instant_high) begin
            mode_d = MODE_PERFORMANCE;
          end else begin
            mode_d = MODE_BALANCE;
          end
        end
      end
      if (mode_d > MODE_GAMING) begin
        mode_d = MODE_OFF;
      end
    end else if (is_set) begin
      if (item_q.display_on && (item_q.level != 3'd0) && auto_en_q) begin
        mode_d = item_q.level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      boost_q <= 1'b0;
    end else if (advance) begin
      mode_q  <= mode_d;
      boost_q <= boost_d;
    end
  end

  always_comb begin
    res_d.mode              = mode_d;
    res_d.boost             = boost_d;
    res_d.gpu_instant_high  = gpu_flags.instant_high;
    res_d.gpu_longtime_high = gpu_flags.longtime_high;
    res_d.cpu_long_perf     = long_perf;
    res_d.cpu_long_prime    = long_prime;
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.mode              = res_q.mode;
  assign result_o.boost             = res_q.boost;
  assign result_o.gpu_instant_high  = res_q.gpu_instant_high;
  assign result_o.gpu_longtime_high = res_q.gpu_longtime_high;
  assign result_o.cpu_long_perf     = res_q.cpu_long_perf;
  assign result_o.cpu_long_prime    = res_q.cpu_long_prime;

`ifndef SYNTHESIS
  // a query never leaves an out-of-range mode behind
  a_query_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_query) |=> (res_q.mode <= MODE_GAMING && mode_q == res_q.mode))
    else $error("query left mode above gaming");

  // display off with auto selection forces save mode
  a_display_off_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_query && auto_en_q && !item_q.display_on) |=> (res_q.mode == MODE_SAVE))
    else $error("display-off query did not select save mode");

  // an empty output slot never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> item_i.ready)
    else $error("input stalled with empty output register");

  // every advanced item shows up as a result
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item produced no result");
`endif

endmodule

FILE: src/ltps_cpu_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltps_cpu_track
// High-load tracker for one cpu cluster with hold-time long-high flag.
// ----------------------------------------------------------------------------
module ltps_cpu_track (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           upd_i,
  input  logic                           hit_i,
  input  logic [63:0]                    now_i,
  input  logic [ltps_pkg::HOLD_NS_W-1:0] hold_ns_i,
  output logic                           long_high_o
);
  import ltps_pkg::*;

  logic        high_q, high_d;
  logic        long_q, long_d;
  logic [63:0] start_q;
  logic [63:0] elapsed;
  logic        held;

  // elapsed time wraps modulo 2^64
  assign elapsed = now_i - start_q;
  assign held    = elapsed > 64'(hold_ns_i);

  always_comb begin
    high_d = high_q;
    long_d = long_q;
    if (upd_i) begin
      if (!high_q) begin
        if (hit_i) begin
          high_d = 1'b1;
        end
      end else if (hit_i) begin
        if (held) begin
          long_d = 1'b1;
        end
      end else begin
        high_d = 1'b0;
        long_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= 1'b0;
      long_q <= 1'b0;
    end else begin
      high_q <= high_d;
      long_q <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i && !high_q && hit_i) begin
      start_q <= now_i;
    end
  end

  assign long_high_o = long_d;

endmodule

FILE: src/ltps_gpu_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltps_gpu_track
// Saturating instant and long-term gpu step counters with hysteresis flags.
// ----------------------------------------------------------------------------
module ltps_gpu_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  logic [31:0]           frequency_i,
  input  logic [6:0]            gpu_busy_i,
  input  logic                  cpu_long_perf_i,
  input  logic                  cpu_long_prime_i,
  output ltps_pkg::gpu_flags_t  flags_o
);
  import ltps_pkg::*;

  logic signed [7:0]  inst_q, inst_d, inst_sum;
  logic signed [12:0] long_q, long_d, long_sum, long_base;
  gpu_flags_t         flags_q, flags_d;

  logic [7:0] bal, busy, up_thr, hi_thr, dn_thr;
  logic       busy_up, busy_hi, busy_dn;
  logic       f600, f550, f500, f450, f400;

  always_comb begin
    bal    = (cpu_long_perf_i ? 8'd5 : 8'd0) + (cpu_long_prime_i ? 8'd10 : 8'd0);
    busy   = {1'b0, gpu_busy_i};
    up_thr = BUSY_UP - bal;
    hi_thr = BUSY_HI - bal;
    dn_thr = BUSY_DN + bal;
    busy_up = busy > up_thr;
    busy_hi = busy > hi_thr;
    busy_dn = busy >= dn_thr;
    f600 = frequency_i >= GPU_FREQ_600;
    f550 = frequency_i >= GPU_FREQ_550;
    f500 = frequency_i >= GPU_FREQ_500;
    f450 = frequency_i >= GPU_FREQ_450;
    f400 = frequency_i >= GPU_FREQ_400;

    // a fast sample restarts a negative instant counter from zero before the increment
    if (f600) begin
      inst_sum = ((inst_q < 8'sd0) ? 8'sd0 : inst_q) + 8'sd1;
    end else begin
      inst_sum = inst_q - 8'sd1;
    end

    long_base = long_q;
    if (f600 && busy_up) begin
      long_sum = long_q + (busy_hi ? 13'sd5 : 13'sd4);
    end else if (f550 && busy_up) begin
      long_sum = long_q + 13'sd2;
    end else if (f500 && busy_up) begin
      long_sum = long_q + 13'sd1;
    end else if (!f500 && busy_dn) begin
      long_sum = long_q - 13'sd2;
    end else if (!f450 && !busy_dn) begin
      long_sum = long_q - 13'sd5;
    end else if (!f400) begin
      long_base = (long_q > 13'sd0) ? 13'sd0 : long_q;
      long_sum  = long_base - (flags_q.longtime_high ? 13'sd5 : 13'sd10);
    end else begin
      long_sum = long_q;
    end

    inst_d  = inst_q;
    long_d  = long_q;
    flags_d = flags_q;
    if (upd_i) begin
      if (inst_sum > INST_MAX) begin
        inst_d = INST_MAX;
      end else if (inst_sum < INST_MIN) begin
        inst_d = INST_MIN;
      end else begin
        inst_d = inst_sum;
      end
      if (inst_d > INST_SET) begin
        flags_d.instant_high = 1'b1;
      end else if (inst_d < INST_CLR) begin
        flags_d.instant_high = 1'b0;
      end

      if (long_sum > LONG_MAX) begin
        long_d = LONG_MAX;
      end else if (long_sum < LONG_MIN) begin
        long_d = LONG_MIN;
      end else begin
        long_d = long_sum;
      end
      if (long_d > LONG_SET) begin
        flags_d.longtime_high = 1'b1;
      end else if (long_d < LONG_CLR) begin
        flags_d.longtime_high = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_q  <= '0;
      long_q  <= '0;
      flags_q <= '0;
    end else begin
      inst_q  <= inst_d;
      long_q  <= long_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_d;

endmodule
